### design/ieu_pkg.sv
// Shared codes, widths and control bundles of the instruction execute unit.
package ieu_pkg;

  // Data word and variable index widths, and the default memory depth
  localparam int unsigned DW            = 32;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned MEM_DEPTH_DEF = 1024;

  // Instruction kinds
  localparam logic [2:0] OP_NOOP   = 3'd0;
  localparam logic [2:0] OP_IN     = 3'd1;
  localparam logic [2:0] OP_OUT    = 3'd2;
  localparam logic [2:0] OP_ASSIGN = 3'd3;
  localparam logic [2:0] OP_CJMP   = 3'd4;
  localparam logic [2:0] OP_JMP    = 3'd5;

  // Assign operators
  localparam logic [2:0] ALU_COPY = 3'd0;
  localparam logic [2:0] ALU_ADD  = 3'd1;
  localparam logic [2:0] ALU_SUB  = 3'd2;
  localparam logic [2:0] ALU_MUL  = 3'd3;
  localparam logic [2:0] ALU_DIV  = 3'd4;

  // Conditional jump tests
  localparam logic [1:0] COND_GT = 2'd0;
  localparam logic [1:0] COND_LT = 2'd1;
  localparam logic [1:0] COND_NE = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIV0 = 2'd1;
  localparam logic [1:0] ERR_BAD  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // capture request and read both operands
    logic clear_en;   // write one zero word of the clearing pass
    logic div_start;  // launch the divider
    logic commit;     // write back and load the result register
  } ieu_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_div;   // current request is a divide by a nonzero value
    logic div_done;   // divider holds a finished quotient
    logic clear_last; // clearing pass is at its final word
  } ieu_sts_t;

endpackage

### design/ieu_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
module ieu_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ieu_pkg::DW-1:0] dividend_i,
  input  logic [ieu_pkg::DW-1:0] divisor_i,
  output logic                  done_o,
  output logic [ieu_pkg::DW-1:0] quotient_o
);
  import ieu_pkg::*;

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [DW-1:0] mdiv_q, mdiv_d;
  logic          neg_q, neg_d;

  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, mdiv_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mdiv_d = mdiv_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[DW-1] ? (DW'(0) - dividend_i) : dividend_i;
      mdiv_d = divisor_i[DW-1] ? (DW'(0) - divisor_i) : divisor_i;
      neg_d  = dividend_i[DW-1] ^ divisor_i[DW-1];
    end else if (busy_q) begin
      if (diff[DW+1]) begin
        rem_d = rem_sh[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end else begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Advance the working registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    mdiv_q <= mdiv_d;
    neg_q  <= neg_d;
  end

  // Restore the sign; the most negative over minus one wraps
  assign done_o     = done_q;
  assign quotient_o = neg_q ? (DW'(0) - quo_q) : quo_q;

endmodule

### design/ieu_dpath.sv
// Datapath: data memory, operand decode, arithmetic and result register.
module ieu_dpath #(
  parameter int unsigned MEM_DEPTH = ieu_pkg::MEM_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ieu_pkg::ieu_cmd_t        cmd_i,
  output ieu_pkg::ieu_sts_t        sts_o,
  input  logic [2:0]               op_i,
  input  logic [2:0]               alu_op_i,
  input  logic [1:0]               condition_i,
  input  logic [ieu_pkg::IDX_W-1:0] index_a_i,
  input  logic [ieu_pkg::IDX_W-1:0] index_b_i,
  input  logic [ieu_pkg::IDX_W-1:0] dest_index_i,
  input  logic signed [ieu_pkg::DW-1:0] input_value_i,
  output logic                     out_valid_o,
  output logic signed [ieu_pkg::DW-1:0] out_value_o,
  output logic                     take_target_o,
  output logic [1:0]               error_o
);
  import ieu_pkg::*;

  localparam int unsigned AW    = $clog2(MEM_DEPTH);
  localparam int unsigned EXT_W = ((AW > IDX_W) ? AW : IDX_W) + 1;

  // Index into the memory and its range check
  function automatic logic [AW-1:0] idx_addr(input logic [IDX_W-1:0] idx);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(idx);
    return ext[AW-1:0];
  endfunction

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return EXT_W'(idx) < EXT_W'(MEM_DEPTH);
  endfunction

  logic [DW-1:0]    mem [MEM_DEPTH];
  logic [DW-1:0]    rd_a_q, rd_b_q;
  logic             a_ok_q, b_ok_q;
  logic [2:0]       op_q, alu_q;
  logic [1:0]       cond_q;
  logic [IDX_W-1:0] ia_q, dest_q;
  logic [DW-1:0]    ival_q;
  logic [AW-1:0]    clr_cnt_q;

  logic [DW-1:0]    opa, opb, mul_lo, quot;
  logic             div_done;
  logic             wr_req, need_div;
  logic [IDX_W-1:0] wr_idx;
  logic [DW-1:0]    res_val;
  logic             r_valid, r_take;
  logic [DW-1:0]    r_value;
  logic [1:0]       r_err;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [DW-1:0]    wdata;

  // Capture the request as it is taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_i;
      alu_q  <= alu_op_i;
      cond_q <= condition_i;
      ia_q   <= index_a_i;
      dest_q <= dest_index_i;
      ival_q <= input_value_i;
      a_ok_q <= idx_ok(index_a_i);
      b_ok_q <= idx_ok(index_b_i);
    end
  end

  // Step the clearing pass through every word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // Data memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.accept) begin
      rd_a_q <= mem[idx_addr(index_a_i)];
      rd_b_q <= mem[idx_addr(index_b_i)];
    end
  end

  // Out-of-range variables read as zero
  assign opa    = a_ok_q ? rd_a_q : '0;
  assign opb    = b_ok_q ? rd_b_q : '0;
  assign mul_lo = opa * opb;

  ieu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (opa),
    .divisor_i  (opb),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Decode the instruction and select its result
  always_comb begin
    wr_req   = 1'b0;
    need_div = 1'b0;
    wr_idx   = dest_q;
    res_val  = '0;
    r_valid  = 1'b0;
    r_value  = '0;
    r_take   = 1'b0;
    r_err    = ERR_NONE;
    case (op_q)
      OP_NOOP: begin
      end
      OP_IN: begin
        wr_req  = 1'b1;
        wr_idx  = ia_q;
        res_val = ival_q;
      end
      OP_OUT: begin
        r_valid = 1'b1;
        r_value = opa;
      end
      OP_ASSIGN: begin
        wr_req = 1'b1;
        case (alu_q)
          ALU_COPY: res_val = opa;
          ALU_ADD:  res_val = opa + opb;
          ALU_SUB:  res_val = opa - opb;
          ALU_MUL:  res_val = mul_lo;
          ALU_DIV: begin
            if (opb == '0) begin
              res_val = '0;
              r_err   = ERR_DIV0;
            end else begin
              need_div = 1'b1;
              res_val  = quot;
            end
          end
          default: begin
            wr_req = 1'b0;
            r_err  = ERR_BAD;
          end
        endcase
      end
      OP_CJMP: begin
        // Take the target when the test fails
        case (cond_q)
          COND_GT: r_take = !($signed(opa) > $signed(opb));
          COND_LT: r_take = !($signed(opa) < $signed(opb));
          COND_NE: r_take = !(opa != opb);
          default: r_err  = ERR_BAD;
        endcase
      end
      OP_JMP: r_take = 1'b1;
      default: r_err = ERR_BAD;
    endcase
  end

  // Write back on commit, zeros during the clearing pass
  assign we    = cmd_i.clear_en | (cmd_i.commit & wr_req & idx_ok(wr_idx));
  assign waddr = cmd_i.clear_en ? clr_cnt_q : idx_addr(wr_idx);
  assign wdata = cmd_i.clear_en ? '0 : res_val;

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_valid_o   <= r_valid;
      out_value_o   <= r_value;
      take_target_o <= r_take;
      error_o       <= r_err;
    end
  end

  assign sts_o.need_div   = need_div;
  assign sts_o.div_done   = div_done;
  assign sts_o.clear_last = (clr_cnt_q == AW'(MEM_DEPTH - 1));

endmodule

### design/ieu_ctrl.sv
// Controller: clearing pass, request sequencing and result handshake.
module ieu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  output ieu_pkg::ieu_cmd_t cmd_o,
  input  ieu_pkg::ieu_sts_t sts_i
);
  import ieu_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       res_valid_q, res_valid_d;
  logic       out_free;

  // The result register is free when empty or being taken
  assign out_free = !res_valid_q || !res_stall_i;

  // Sequence each request
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done && out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Set on commit, drop once taken
  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_o.commit) begin
      res_valid_d = 1'b1;
    end else if (!res_stall_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;

endmodule

### design/ir_instruction_execute_unit.sv
// Top level of the intermediate-code instruction execute unit.
// Executes one three-address instruction per request against MEM_DEPTH signed
// 32-bit variables and returns one result per request. After reset a clearing
// pass writes zero to every variable, one word per cycle, and in_stall_o stays
// high until the pass has written the last word. A request is taken in the
// idle state, which also reads both operands, and executed in the execute
// state; a divide first runs the radix-2 divider through its 32 quotient steps.
// in_stall_o stays high from taking a request until its result is committed,
// which waits for the result register to be free. The result register lets a
// new request be taken while the previous result waits on res_stall_i.
// Variables at or beyond MEM_DEPTH read as zero and ignore writes.
module ir_instruction_execute_unit #(
  parameter int unsigned MEM_DEPTH = ieu_pkg::MEM_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    op_i,
  input  logic [2:0]                    alu_op_i,
  input  logic [1:0]                    condition_i,
  input  logic [ieu_pkg::IDX_W-1:0]     index_a_i,
  input  logic [ieu_pkg::IDX_W-1:0]     index_b_i,
  input  logic [ieu_pkg::IDX_W-1:0]     dest_index_i,
  input  logic signed [ieu_pkg::DW-1:0] input_value_i,
  output logic                          res_valid_o,
  input  logic                          res_stall_i,
  output logic                          out_valid_o,
  output logic signed [ieu_pkg::DW-1:0] out_value_o,
  output logic                          take_target_o,
  output logic [1:0]                    error_o
);
  import ieu_pkg::*;

  ieu_cmd_t cmd;
  ieu_sts_t sts;

  ieu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ieu_dpath #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .alu_op_i      (alu_op_i),
    .condition_i   (condition_i),
    .index_a_i     (index_a_i),
    .index_b_i     (index_b_i),
    .dest_index_i  (dest_index_i),
    .input_value_i (input_value_i),
    .out_valid_o   (out_valid_o),
    .out_value_o   (out_value_o),
    .take_target_o (take_target_o),
    .error_o       (error_o)
  );

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the intermediate-code instruction execute unit.
module tb;
  import ieu_pkg::*;

  localparam int unsigned VAR_COUNT   = MEM_DEPTH_DEF;
  localparam int          IDLE_LIMIT  = 4000;
  localparam int          LONG_HOLD   = 400;
  localparam int          SETTLE_CYC  = 40;
  localparam int          POOL_SIZE   = 12;

  // Codes outside the defined sets
  localparam logic [2:0] OP_BAD_LO  = 3'd6;
  localparam logic [2:0] OP_BAD_HI  = 3'd7;
  localparam logic [2:0] ALU_BAD_LO = 3'd5;
  localparam logic [2:0] ALU_BAD_HI = 3'd7;
  localparam logic [1:0] COND_BAD   = 2'd3;

  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_M1  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]       op;
    logic [2:0]       alu;
    logic [1:0]       cond;
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    logic [IDX_W-1:0] id;
    logic [DW-1:0]    val;
  } instr_t;

  typedef struct packed {
    logic          out_valid;
    logic [DW-1:0] out_value;
    logic          take;
    logic [1:0]    err;
  } outcome_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_stall_o;
  logic [2:0]             op_i          = OP_NOOP;
  logic [2:0]             alu_op_i      = ALU_COPY;
  logic [1:0]             condition_i   = COND_GT;
  logic [IDX_W-1:0]       index_a_i     = '0;
  logic [IDX_W-1:0]       index_b_i     = '0;
  logic [IDX_W-1:0]       dest_index_i  = '0;
  logic signed [DW-1:0]   input_value_i = '0;
  logic                   res_valid_o;
  logic                   res_stall_i   = 1'b0;
  logic                   out_valid_o;
  logic signed [DW-1:0]   out_value_o;
  logic                   take_target_o;
  logic [1:0]             error_o;

  // Shadow of the variable store, the outcomes still owed by the block and the pool of live variables
  logic [DW-1:0]          var_shadow [VAR_COUNT];
  outcome_t               pending_outcomes [$];
  logic [IDX_W-1:0]       var_pool [POOL_SIZE];

  int  err_count   = 0;
  int  quiet_cycles = 0;
  bit  tx_burst    = 1'b0;
  bit  rx_steady   = 1'b0;
  bit  hold_req    = 1'b0;
  int  hold_left   = 0;
  int  stall_left  = 0;

  ir_instruction_execute_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .alu_op_i      (alu_op_i),
    .condition_i   (condition_i),
    .index_a_i     (index_a_i),
    .index_b_i     (index_b_i),
    .dest_index_i  (dest_index_i),
    .input_value_i (input_value_i),
    .res_valid_o   (res_valid_o),
    .res_stall_i   (res_stall_i),
    .out_valid_o   (out_valid_o),
    .out_value_o   (out_value_o),
    .take_target_o (take_target_o),
    .error_o       (error_o)
  );

  always #6 clk_i = ~clk_i;

  // Read a variable; indexes beyond the store read as zero
  function automatic logic [DW-1:0] read_var(logic [IDX_W-1:0] idx);
    if (idx < VAR_COUNT) return var_shadow[idx];
    return '0;
  endfunction

  // Write a variable; indexes beyond the store are dropped
  function automatic void write_var(logic [IDX_W-1:0] idx, logic [DW-1:0] v);
    if (idx < VAR_COUNT) var_shadow[idx] = v;
  endfunction

  // Truncating signed quotient; divisor is nonzero
  function automatic logic [DW-1:0] trunc_quotient(logic [DW-1:0] a, logic [DW-1:0] b);
    logic [DW-1:0] ma;
    logic [DW-1:0] mb;
    logic [DW-1:0] q;
    ma = a[DW-1] ? -a : a;
    mb = b[DW-1] ? -b : b;
    q  = ma / mb;
    return (a[DW-1] ^ b[DW-1]) ? -q : q;
  endfunction

  // Execute one instruction against the shadow store and return its outcome
  function automatic outcome_t execute_instr(instr_t ins);
    outcome_t      res;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] r;
    logic          holds;
    res = '0;
    a   = read_var(ins.ia);
    b   = read_var(ins.ib);
    case (ins.op)
      OP_NOOP: ;
      OP_IN:   write_var(ins.ia, ins.val);
      OP_OUT: begin
        res.out_valid = 1'b1;
        res.out_value = a;
      end
      OP_ASSIGN: begin
        case (ins.alu)
          ALU_COPY: write_var(ins.id, a);
          ALU_ADD:  write_var(ins.id, a + b);
          ALU_SUB:  write_var(ins.id, a - b);
          ALU_MUL:  write_var(ins.id, a * b);
          ALU_DIV: begin
            if (b == '0) begin
              r       = '0;
              res.err = ERR_DIV0;
            end else begin
              r = trunc_quotient(a, b);
            end
            write_var(ins.id, r);
          end
          default: res.err = ERR_BAD;
        endcase
      end
      OP_CJMP: begin
        case (ins.cond)
          COND_GT: holds = $signed(a) > $signed(b);
          COND_LT: holds = $signed(a) < $signed(b);
          COND_NE: holds = a != b;
          default: res.err = ERR_BAD;
        endcase
        // a failing test branches to the target
        if (res.err == ERR_NONE) res.take = !holds;
      end
      OP_JMP:  res.take = 1'b1;
      default: res.err = ERR_BAD;
    endcase
    return res;
  endfunction

  function automatic instr_t make_instr(logic [2:0] op, logic [2:0] alu, logic [1:0] cond,
                                        logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib,
                                        logic [IDX_W-1:0] id, logic [DW-1:0] val);
    instr_t ins;
    ins.op   = op;
    ins.alu  = alu;
    ins.cond = cond;
    ins.ia   = ia;
    ins.ib   = ib;
    ins.id   = id;
    ins.val  = val;
    return ins;
  endfunction

  // Data word biased towards the edges of the signed range
  function automatic logic [DW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'd1;
      2:       return WORD_M1;
      3:       return WORD_MIN;
      4:       return WORD_MAX;
      5:       return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  // Idle cycles before the next request: mostly none or short, a few long
  function automatic int tx_gap();
    int r;
    if (tx_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [IDX_W-1:0] pick_var();
    return var_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Random instruction, mostly over a small set of live variables, with occasional invalid codes
  function automatic instr_t random_program_instr();
    int     r;
    instr_t ins;
    r   = $urandom_range(0, 99);
    ins = make_instr(OP_NOOP, 3'($urandom), 2'($urandom), pick_var(), pick_var(),
                     pick_var(), rand_word());
    if (r < 20) begin
      ins.op = OP_IN;
      if ($urandom_range(0, 9) == 0) ins.ia = IDX_W'($urandom);
    end else if (r < 35) begin
      ins.op = OP_OUT;
    end else if (r < 75) begin
      ins.op  = OP_ASSIGN;
      ins.alu = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(ALU_BAD_LO, ALU_BAD_HI))
                                             : 3'($urandom_range(ALU_COPY, ALU_DIV));
    end else if (r < 90) begin
      ins.op   = OP_CJMP;
      ins.cond = ($urandom_range(0, 19) == 0) ? COND_BAD : 2'($urandom_range(0, 2));
    end else if (r < 94) begin
      ins.op = OP_JMP;
    end else if (r < 97) begin
      ins.op = OP_NOOP;
    end else begin
      ins.op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
    end
    return ins;
  endfunction

  // Offer one request and hold it until accepted; record its outcome
  task automatic send_instr(instr_t ins);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= ins.op;
    alu_op_i      <= ins.alu;
    condition_i   <= ins.cond;
    index_a_i     <= ins.ia;
    index_b_i     <= ins.ib;
    dest_index_i  <= ins.id;
    input_value_i <= ins.val;
    do @(posedge clk_i); while (in_stall_o);
    pending_outcomes.push_back(execute_instr(ins));
  endtask

  // Drop the request line and idle
  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Edges of every field, every operation and each corner case
  task automatic test_directed();
    send_instr(make_instr(OP_IN, ALU_COPY, COND_GT, 10'd0, 10'd0, 10'd0, WORD_MAX));
    send_instr(make_instr(OP_IN, ALU_COPY, COND_GT, 10'd1023, 10'd0, 10'd0, WORD_MIN));
    send_instr(make_instr(OP_IN, ALU_COPY, COND_GT, 10'd5, 10'd0, 10'd0, WORD_M1));
    send_instr(make_instr(OP_IN, ALU_COPY, COND_GT, 10'd9, 10'd0, 10'd0, -32'sd7));
    send_instr(make_instr(OP_IN, ALU_COPY, COND_GT, 10'd10, 10'd0, 10'd0, 32'd2));
    send_instr(make_instr(OP_IN, ALU_COPY, COND_GT, 10'd12, 10'd0, 10'd0, 32'd1));
    send_instr(make_instr(OP_OUT, ALU_COPY, COND_GT, 10'd1023, 10'd0, 10'd0, '0));
    // wrap on add and subtract, low word of product
    send_instr(make_instr(OP_ASSIGN, ALU_ADD, COND_GT, 10'd0, 10'd12, 10'd11, '0));
    send_instr(make_instr(OP_ASSIGN, ALU_SUB, COND_GT, 10'd1023, 10'd12, 10'd13, '0));
    send_instr(make_instr(OP_ASSIGN, ALU_MUL, COND_GT, 10'd0, 10'd0, 10'd14, '0));
    // most negative over minus one, truncation towards zero, divide by zero
    send_instr(make_instr(OP_ASSIGN, ALU_DIV, COND_GT, 10'd1023, 10'd5, 10'd15, '0));
    send_instr(make_instr(OP_ASSIGN, ALU_DIV, COND_GT, 10'd9, 10'd10, 10'd16, '0));
    send_instr(make_instr(OP_ASSIGN, ALU_DIV, COND_GT, 10'd0, 10'd6, 10'd1023, '0));
    send_instr(make_instr(OP_ASSIGN, ALU_COPY, COND_GT, 10'd9, 10'd0, 10'd18, '0));
    // invalid operators leave the destination alone
    send_instr(make_instr(OP_ASSIGN, ALU_BAD_LO, COND_GT, 10'd9, 10'd10, 10'd0, '0));
    send_instr(make_instr(OP_ASSIGN, ALU_BAD_HI, COND_GT, 10'd9, 10'd10, 10'd0, '0));
    send_instr(make_instr(OP_OUT, ALU_COPY, COND_GT, 10'd0, 10'd0, 10'd0, '0));
    send_instr(make_instr(OP_CJMP, ALU_COPY, COND_GT, 10'd0, 10'd9, 10'd0, '0));
    send_instr(make_instr(OP_CJMP, ALU_COPY, COND_LT, 10'd0, 10'd9, 10'd0, '0));
    send_instr(make_instr(OP_CJMP, ALU_COPY, COND_NE, 10'd6, 10'd1023, 10'd0, '0));
    send_instr(make_instr(OP_CJMP, ALU_COPY, COND_BAD, 10'd0, 10'd9, 10'd0, '0));
    send_instr(make_instr(OP_JMP, ALU_BAD_HI, COND_BAD, 10'd1023, 10'd1023, 10'd1023,
                          WORD_M1));
    send_instr(make_instr(OP_NOOP, ALU_BAD_HI, COND_BAD, 10'd1023, 10'd1023, 10'd1023,
                          WORD_M1));
    send_instr(make_instr(OP_BAD_LO, ALU_COPY, COND_GT, 10'd0, 10'd0, 10'd0, WORD_MAX));
    send_instr(make_instr(OP_BAD_HI, ALU_COPY, COND_GT, 10'd0, 10'd0, 10'd0, WORD_MIN));
    drop_valid();
  endtask

  // Random programs in chunks, some chunks with idling switched off
  task automatic test_random_programs(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        for (int k = 0; k < POOL_SIZE; k++) var_pool[k] = IDX_W'($urandom);
        var_pool[0] = '0;
        var_pool[1] = '1;
        tx_burst    = ($urandom_range(0, 3) == 0);
        rx_steady   = ($urandom_range(0, 3) == 0);
      end
      send_instr(random_program_instr());
    end
    tx_burst  = 1'b0;
    rx_steady = 1'b0;
    drop_valid();
  endtask

  // Long receiver hold-off while requests keep arriving back to back
  task automatic test_backpressure(int count);
    tx_burst = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < count; i++) send_instr(random_program_instr());
    tx_burst = 1'b0;
    drop_valid();
  endtask

  // Pause the sender until the block has returned every outcome
  task automatic test_drain_pause(int count);
    for (int i = 0; i < count; i++) send_instr(random_program_instr());
    drop_valid();
    wait_drained();
    for (int i = 0; i < count; i++) send_instr(random_program_instr());
    drop_valid();
  endtask

  // Unconstrained fields
  task automatic test_noise(int count);
    for (int i = 0; i < count; i++)
      send_instr(make_instr(3'($urandom), 3'($urandom), 2'($urandom), IDX_W'($urandom),
                            IDX_W'($urandom), IDX_W'($urandom), $urandom));
    drop_valid();
  endtask

  // Check each accepted outcome and choose the next stall
  always @(posedge clk_i) begin
    outcome_t exp_res;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        err_count++;
      end else begin
        exp_res = pending_outcomes.pop_front();
        if (out_valid_o !== exp_res.out_valid) begin
          $display("%0t: out_valid expected %0b got %0b", $time, exp_res.out_valid,
                   out_valid_o);
          err_count++;
        end
        if (out_value_o !== exp_res.out_value) begin
          $display("%0t: out_value expected %0d got %0d", $time,
                   $signed(exp_res.out_value), out_value_o);
          err_count++;
        end
        if (take_target_o !== exp_res.take) begin
          $display("%0t: take_target expected %0b got %0b", $time, exp_res.take,
                   take_target_o);
          err_count++;
        end
        if (error_o !== exp_res.err) begin
          $display("%0t: error expected %0d got %0d", $time, exp_res.err, error_o);
          err_count++;
        end
      end
    end
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall_i <= 1'b1;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      stall_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= 1'b0;
    end
  end

  // Stop the run when neither side moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (res_valid_o && !res_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < VAR_COUNT; k++) var_shadow[k] = '0;
    for (int k = 0; k < POOL_SIZE; k++) var_pool[k] = IDX_W'(k);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_programs(1450);
    test_backpressure(100);
    test_drain_pause(40);
    test_noise(200);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
design/ieu_pkg.sv
design/ieu_div.sv
design/ieu_dpath.sv
design/ieu_ctrl.sv
design/ir_instruction_execute_unit.sv
tb/sv/tb.sv
